// ===== rtl/lgge_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared codes and constants of the life grid generation engine (rule B3/S23).
// ----------------------------------------------------------------------------
package lgge_pkg;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Grid storage defaults
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam logic [6:0] EXTENT_RESET = 7'd64;

  // Neighbor counts of the life rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Digest and population limits
  localparam int DIGEST_MOD = 10000007;
  localparam logic [12:0] POP_MAX = 13'd8191;

endpackage : lgge_pkg
`default_nettype wire

// ===== rtl/lgge_col_rule.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgge_col_rule
// Next generation of one grid column from the old column and its two
// neighbor columns. Rows outside the mask count as dead and keep their bits.
// ----------------------------------------------------------------------------
module lgge_col_rule #(
  parameter int MAX_HEIGHT = lgge_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic [MAX_HEIGHT-1:0] prev_col,
  input  wire logic [MAX_HEIGHT-1:0] cur_col,
  input  wire logic [MAX_HEIGHT-1:0] nxt_col,
  input  wire logic [MAX_HEIGHT-1:0] row_mask,
  output logic      [MAX_HEIGHT-1:0] new_col
);
  import lgge_pkg::*;

  logic [MAX_HEIGHT+1:0] pa;
  logic [MAX_HEIGHT+1:0] pb;
  logic [MAX_HEIGHT+1:0] pc;

  // Pad each masked column with a dead cell above and below
  assign pa = {1'b0, prev_col & row_mask, 1'b0};
  assign pb = {1'b0, cur_col  & row_mask, 1'b0};
  assign pc = {1'b0, nxt_col  & row_mask, 1'b0};

  always_comb begin
    logic [3:0] n;
    for (int y = 0; y < MAX_HEIGHT; y++) begin
      n = 4'(pa[y]) + 4'(pa[y+1]) + 4'(pa[y+2])
        + 4'(pb[y])               + 4'(pb[y+2])
        + 4'(pc[y]) + 4'(pc[y+1]) + 4'(pc[y+2]);
      if (row_mask[y]) begin
        new_col[y] = (n == BIRTH_COUNT) || (cur_col[y] && (n == SURVIVE_COUNT));
      end else begin
        new_col[y] = cur_col[y];
      end
    end
  end

endmodule : lgge_col_rule
`default_nettype wire

// ===== rtl/life_grid_generation_engine_unit.sv =====
`default_nettype none
// Cell write or read: the request goes through S_CELL and S_FINISH, which registers
// the result (S_FINISH alone for coordinates outside the extent or an unused code).
// Step: S_LOAD, then S_COMPUTE and S_SCAN for each column, then S_FINISH; the rule
// unit makes one column per pass and the digest takes one cell a cycle.
// One request at a time; a new request is taken while a result still waits.
// Reset: grid cleared by a pass over all MAX_WIDTH columns, requests stalled; extents 64.
// ----------------------------------------------------------------------------
// life_grid_generation_engine_unit
// Life grid engine, rule B3/S23. The grid lives in a column-wide memory; a
// step walks the columns with a three-column window and hashes the result.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_unit #(
  parameter int MAX_WIDTH  = lgge_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lgge_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  // requests
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [6:0]  cell_x,
  input  wire logic [6:0]  cell_y,
  input  wire logic        cell_value,
  // results
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic             ok,
  output logic             read_value,
  output logic [12:0]      population,
  output logic             all_dead,
  output logic [23:0]      digest
);
  import lgge_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int YA  = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CXW = (WW > 7) ? WW : 7;
  localparam int CYW = (HW > 7) ? HW : 7;
  localparam logic [25:0] MOD1 = 26'(DIGEST_MOD);
  localparam logic [25:0] MOD2 = 26'(2 * DIGEST_MOD);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CELL, S_LOAD, S_COMPUTE, S_SCAN, S_FINISH
  } state_t;

  state_t state;

  logic [6:0] grid_width;
  logic [6:0] grid_height;

  // Column memory: one entry per x, one bit per y
  logic [MAX_HEIGHT-1:0] mem [MAX_WIDTH];
  logic [MAX_HEIGHT-1:0] rdata;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [MAX_HEIGHT-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;

  // Clamped extents
  logic [CXW-1:0] gw_full;
  logic [CYW-1:0] gh_full;
  logic [WW-1:0]  ext_w;
  logic [HW-1:0]  ext_h;
  logic [MAX_HEIGHT-1:0] row_mask;

  // Request decode
  logic [CXW-1:0] x_full;
  logic [CYW-1:0] y_full;
  logic           coord_ok;
  logic           req_take;
  logic           rsp_load;

  // Working registers
  logic [1:0]            req;
  logic                  wval;
  logic [AW-1:0]         xaddr;
  logic [YA-1:0]         yidx;
  logic [AW-1:0]         clr_cnt;
  logic [AW-1:0]         xcnt;
  logic [YA-1:0]         ycnt;
  logic [MAX_HEIGHT-1:0] prev_col;
  logic [MAX_HEIGHT-1:0] cur_col;
  logic [MAX_HEIGHT-1:0] nxt_col;
  logic [MAX_HEIGHT-1:0] new_col;
  logic [MAX_HEIGHT-1:0] scol;
  logic                  res_ok;
  logic                  res_rv;
  logic [12:0]           pop;
  logic [23:0]           dig;

  logic [AW:0]   x_plus1;
  logic [AW:0]   x_plus2;
  logic          more_cols;
  logic          read_ahead;
  logic          last_row;
  logic [25:0]   dig_sum;
  logic [23:0]   dig_next;
  logic [MAX_HEIGHT-1:0] cell_col;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_load  = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  // Extents: zero acts as one, anything past the storage acts as its size
  assign gw_full = CXW'(grid_width);
  assign gh_full = CYW'(grid_height);

  always_comb begin
    if (gw_full == '0) begin
      ext_w = WW'(1);
    end else if (gw_full > CXW'(MAX_WIDTH)) begin
      ext_w = WW'(MAX_WIDTH);
    end else begin
      ext_w = WW'(gw_full);
    end
    if (gh_full == '0) begin
      ext_h = HW'(1);
    end else if (gh_full > CYW'(MAX_HEIGHT)) begin
      ext_h = HW'(MAX_HEIGHT);
    end else begin
      ext_h = HW'(gh_full);
    end
  end

  always_comb begin
    for (int y = 0; y < MAX_HEIGHT; y++) begin
      row_mask[y] = (y < int'(ext_h));
    end
  end

  assign x_full   = CXW'(cell_x);
  assign y_full   = CYW'(cell_y);
  assign coord_ok = (x_full < CXW'(ext_w)) && (y_full < CYW'(ext_h));

  assign x_plus1    = (AW+1)'(xcnt) + (AW+1)'(1);
  assign x_plus2    = (AW+1)'(xcnt) + (AW+1)'(2);
  assign more_cols  = (x_plus1 < (AW+1)'(ext_w));
  assign read_ahead = (x_plus2 < (AW+1)'(ext_w));
  assign last_row   = ((HW'(ycnt) + HW'(1)) == ext_h);

  // Columns past the extent count as dead
  assign nxt_col = more_cols ? rdata : '0;

  lgge_col_rule #(
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_rule (
    .prev_col (prev_col),
    .cur_col  (cur_col),
    .nxt_col  (nxt_col),
    .row_mask (row_mask),
    .new_col  (new_col)
  );

  // Digest: dig * 3 + cell, reduced below the modulus
  always_comb begin
    logic [25:0] d;
    dig_sum = (26'(dig) << 1) + 26'(dig) + 26'(scol[0]);
    if (dig_sum >= MOD2) begin
      d = dig_sum - MOD2;
    end else if (dig_sum >= MOD1) begin
      d = dig_sum - MOD1;
    end else begin
      d = dig_sum;
    end
    dig_next = d[23:0];
  end

  // Cell write merges one bit into the column just read
  always_comb begin
    cell_col       = rdata;
    cell_col[yidx] = wval;
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = x_full[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (req_take) begin
          if (req_type == REQ_STEP) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
          end else if ((req_type == REQ_WRITE || req_type == REQ_READ) && coord_ok) begin
            mem_re = 1'b1;
          end
        end
      end
      S_CELL: begin
        mem_we    = (req == REQ_WRITE);
        mem_waddr = xaddr;
        mem_wdata = cell_col;
      end
      S_LOAD: begin
        mem_re    = (ext_w > WW'(1));
        mem_raddr = AW'(1);
      end
      S_COMPUTE: begin
        mem_we    = 1'b1;
        mem_waddr = xcnt;
        mem_wdata = new_col;
        mem_re    = read_ahead;
        mem_raddr = x_plus2[AW-1:0];
      end
      S_SCAN, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Control, registers and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      rsp_valid   <= 1'b0;
      grid_width  <= EXTENT_RESET;
      grid_height <= EXTENT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WIDTH:  grid_width  <= cfg_data;
          CFG_HEIGHT: grid_height <= cfg_data;
          default: begin
          end
        endcase
      end

      // load a new result, or drop the old one once its transfer completes
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MAX_WIDTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_take) begin
            req    <= req_type;
            wval   <= cell_value;
            xaddr  <= x_full[AW-1:0];
            yidx   <= y_full[YA-1:0];
            res_ok <= (req_type == REQ_STEP);
            res_rv <= 1'b0;
            pop    <= '0;
            dig    <= '0;
            if (req_type == REQ_STEP) begin
              prev_col <= '0;
              xcnt     <= '0;
              state    <= S_LOAD;
            end else if ((req_type == REQ_WRITE || req_type == REQ_READ) && coord_ok) begin
              state <= S_CELL;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_CELL: begin
          res_ok <= 1'b1;
          if (req == REQ_READ) begin
            res_rv <= rdata[yidx];
          end
          state <= S_FINISH;
        end
        S_LOAD: begin
          cur_col <= rdata;
          state   <= S_COMPUTE;
        end
        S_COMPUTE: begin
          // slide the window; the new column goes out one cell a cycle
          prev_col <= cur_col;
          cur_col  <= nxt_col;
          scol     <= new_col;
          ycnt     <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          scol <= scol >> 1;
          dig  <= dig_next;
          if (pop != POP_MAX) begin
            pop <= pop + 13'(scol[0]);
          end
          ycnt <= ycnt + YA'(1);
          if (last_row) begin
            if (more_cols) begin
              xcnt  <= x_plus1[AW-1:0];
              state <= S_COMPUTE;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          // hold until the result register is free
          if (rsp_load) begin
            ok         <= res_ok;
            read_value <= res_rv;
            population <= pop;
            all_dead   <= (req == REQ_STEP) && (pop == '0);
            digest     <= dig;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : life_grid_generation_engine_unit
`default_nettype wire

// ===== tb/life_grid_checker.sv =====
// ----------------------------------------------------------------------------
// life_grid_checker
// Watches the configuration, request and result channels of the life grid
// engine. Keeps its own copy of the grid and the extents, works out the
// answer of every accepted request and compares each result transfer
// against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module life_grid_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [6:0]  cell_x,
  input  logic [6:0]  cell_y,
  input  logic        cell_value,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic        ok,
  input  logic        read_value,
  input  logic [12:0] population,
  input  logic        all_dead,
  input  logic [23:0] digest,
  output int          fail_count,
  output int          outstanding
);
  import lgge_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;
  localparam int DIGEST_BASE = 3;

  typedef struct packed {
    logic        ok;
    logic        read_value;
    logic [12:0] population;
    logic        all_dead;
    logic [23:0] digest;
  } grid_answer_t;

  logic [MAX_H-1:0] cells   [MAX_W];
  logic [MAX_H-1:0] scratch [MAX_W];
  logic [6:0]       width_reg;
  logic [6:0]       height_reg;
  grid_answer_t     answers [$];
  int               mismatches = 0;

  initial outstanding = 0;
  assign fail_count = mismatches;

  function automatic int fit_extent(input logic [6:0] v, input int cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic predict_answer(input logic [1:0] kind, input logic [6:0] x_in,
                                input logic [6:0] y_in, input logic v_in,
                                output grid_answer_t a);
    int w, h, n, nx, ny;
    int unsigned pop, dig;
    w = fit_extent(width_reg, MAX_W);
    h = fit_extent(height_reg, MAX_H);
    a = '0;
    if (kind == REQ_WRITE || kind == REQ_READ) begin
      if (x_in < w && y_in < h) begin
        a.ok = 1'b1;
        if (kind == REQ_WRITE) cells[x_in][y_in] = v_in;
        else a.read_value = cells[x_in][y_in];
      end
    end else if (kind == REQ_STEP) begin
      for (int x = 0; x < w; x++) begin
        for (int y = 0; y < h; y++) begin
          n = 0;
          for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
              nx = x + dx;
              ny = y + dy;
              if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h)
                n += cells[nx][ny];
            end
          end
          scratch[x][y] = (n == BIRTH_COUNT) || (cells[x][y] && n == SURVIVE_COUNT);
        end
      end
      // commit the new generation and hash it column by column
      pop = 0;
      dig = 0;
      for (int x = 0; x < w; x++) begin
        for (int y = 0; y < h; y++) begin
          cells[x][y] = scratch[x][y];
          if (pop < POP_MAX) pop += scratch[x][y];
          dig = (dig * DIGEST_BASE + scratch[x][y]) % DIGEST_MOD;
        end
      end
      a.ok         = 1'b1;
      a.population = pop[12:0];
      a.all_dead   = (pop == 0);
      a.digest     = dig[23:0];
    end
  endtask

  always @(posedge clk) begin
    grid_answer_t want;
    if (rst) begin
      for (int x = 0; x < MAX_W; x++) cells[x] = '0;
      width_reg  = EXTENT_RESET;
      height_reg = EXTENT_RESET;
      answers.delete();
    end else begin
      // results leaving at this edge belong to earlier requests
      if (rsp_valid && !rsp_stall) begin
        if (answers.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = answers.pop_front();
          check_field("ok", want.ok, ok);
          check_field("read_value", want.read_value, read_value);
          check_field("population", want.population, population);
          check_field("all_dead", want.all_dead, all_dead);
          check_field("digest", want.digest, digest);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (req_valid && !req_stall) begin
        predict_answer(req_type, cell_x, cell_y, cell_value, want);
        answers = {answers, want};
      end
    end
    outstanding <= answers.size();
  end

endmodule

// ===== tb/tb_life_grid_generation_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_life_grid_generation_engine_unit
// Drives the life grid engine through directed cases (grid edges, bad
// coordinates, the unused request code, extent clamping, a blinker, cells
// hidden by a shrunk extent) and then random phases over many extents,
// with random idling on both channels. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb_life_grid_generation_engine_unit;
  import lgge_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 17;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_WIDTH;
  logic [6:0]  cfg_data = '0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  req_type = REQ_WRITE;
  logic [6:0]  cell_x = '0;
  logic [6:0]  cell_y = '0;
  logic        cell_value = 1'b0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        ok;
  logic        read_value;
  logic [12:0] population;
  logic        all_dead;
  logic [23:0] digest;

  int fail_count;
  int outstanding;
  logic quiet = 1'b0;
  int stall_hold = 0;
  int idle_cycles = 0;
  int span_w = MAX_W;
  int span_h = MAX_H;

  always #5 clk = ~clk;

  life_grid_generation_engine_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .cell_x(cell_x), .cell_y(cell_y), .cell_value(cell_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .ok(ok),
    .read_value(read_value), .population(population), .all_dead(all_dead),
    .digest(digest)
  );

  life_grid_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .cell_x(cell_x), .cell_y(cell_y), .cell_value(cell_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .ok(ok),
    .read_value(read_value), .population(population), .all_dead(all_dead),
    .digest(digest),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // result side back-pressure: random stall bursts, none while quiet
  always @(posedge clk) begin
    if (quiet) begin
      rsp_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (rsp_stall || $urandom_range(0, 3) == 0) begin
      rsp_stall  <= ~rsp_stall;
      stall_hold <= $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid stays high after a transfer; it drops only for a gap or a pause
  task automatic issue_request(input logic [1:0] kind, input logic [6:0] x,
                               input logic [6:0] y, input logic v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= kind;
    cell_x     <= x;
    cell_y     <= y;
    cell_value <= v;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_extent(input logic [6:0] w, input logic [6:0] h);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    span_w = (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
    span_h = (h == 0) ? 1 : ((h > MAX_H) ? MAX_H : h);
  endtask

  function automatic logic [6:0] pick_extent();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 7'($urandom_range(1, 8));
    if (r < 6) return 7'($urandom_range(9, 20));
    if (r == 6) return 7'd0;
    if (r == 7) return 7'd64;
    if (r == 8) return 7'($urandom_range(65, 127));
    return 7'($urandom_range(21, 63));
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      issue_request(REQ_WRITE, 7'($urandom_range(0, span_w - 1)),
                    7'($urandom_range(0, span_h - 1)), $urandom_range(0, 9) < 7);
    else if (r < 60)
      issue_request(REQ_READ, 7'($urandom_range(0, span_w - 1)),
                    7'($urandom_range(0, span_h - 1)), 1'($urandom_range(0, 1)));
    else if (r < 75)
      issue_request(REQ_STEP, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    1'($urandom_range(0, 1)));
    else if (r < 95)
      issue_request($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    else
      issue_request(REQ_UNUSED, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // full 64 x 64 grid out of reset: corners, bad coordinates, unused code
    issue_request(REQ_READ, 7'd0, 7'd0, 1'b0);
    issue_request(REQ_WRITE, 7'd63, 7'd63, 1'b1);
    issue_request(REQ_WRITE, 7'd0, 7'd0, 1'b1);
    issue_request(REQ_READ, 7'd63, 7'd63, 1'b0);
    issue_request(REQ_WRITE, 7'd64, 7'd0, 1'b1);
    issue_request(REQ_READ, 7'd127, 7'd127, 1'b0);
    issue_request(REQ_WRITE, 7'd0, 7'd64, 1'b1);
    issue_request(REQ_UNUSED, 7'd127, 7'd127, 1'b1);
    issue_request(REQ_WRITE, 7'd5, 7'd5, 1'b0);
    issue_request(REQ_STEP, 7'd0, 7'd0, 1'b0);

    // blinker in a 5 x 5 grid, two generations
    set_extent(7'd5, 7'd5);
    issue_request(REQ_WRITE, 7'd1, 7'd2, 1'b1);
    issue_request(REQ_WRITE, 7'd2, 7'd2, 1'b1);
    issue_request(REQ_WRITE, 7'd3, 7'd2, 1'b1);
    issue_request(REQ_STEP, 7'd0, 7'd0, 1'b0);
    issue_request(REQ_STEP, 7'd0, 7'd0, 1'b0);
    issue_request(REQ_READ, 7'd2, 7'd2, 1'b0);

    // zero extent acts as a single cell; the blinker stays hidden
    set_extent(7'd0, 7'd0);
    issue_request(REQ_WRITE, 7'd0, 7'd0, 1'b1);
    issue_request(REQ_STEP, 7'd0, 7'd0, 1'b0);
    issue_request(REQ_READ, 7'd1, 7'd0, 1'b0);

    // oversized extent clamps to the full grid; the blinker comes back
    set_extent(7'd127, 7'd127);
    issue_request(REQ_READ, 7'd2, 7'd1, 1'b0);
    issue_request(REQ_READ, 7'd1, 7'd2, 1'b0);
    issue_request(REQ_STEP, 7'd0, 7'd0, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_extent(pick_extent(), pick_extent());
      if (p == RANDOM_PHASES - 1) quiet <= 1'b1;
      repeat (ITEMS_PER_PHASE) random_request();
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
